### rtl/rcdd_pkg.sv
package rcdd_pkg;

   // pulse width at or above which an interval is not taken as a width
   localparam int WIDTH_LIMIT_US = 2000;
   localparam int HELD_W = (WIDTH_LIMIT_US > 1) ? $clog2(WIDTH_LIMIT_US) : 1;

   // dead band around stick center, as inclusive bounds
   localparam logic [11:0] DEAD_LO = 12'd1476;
   localparam logic [11:0] DEAD_HI = 12'd1514;

   // mixing constants: 2000 * V, scale 30 * 113, divisor 256 * 355 * D
   localparam logic [11:0] V_GAIN    = 12'd2000;
   localparam logic [11:0] RPM_SCALE = 12'd3390;
   localparam logic [16:0] DEN_SCALE = 17'd90880;

   // shared divider sizes
   localparam int DIV_NUM_W = 55;
   localparam int DIV_DEN_W = 29;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
   localparam int MAP_MAG_W = 28;
   localparam logic [DIV_CNT_W-1:0] MAP_ITERS = DIV_CNT_W'(MAP_MAG_W);
   localparam logic [DIV_CNT_W-1:0] RPM_ITERS = DIV_CNT_W'(DIV_NUM_W);

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_PULSE_MIN  = 3'd0,
      CSR_PULSE_MAX  = 3'd1,
      CSR_LIN_MIN    = 3'd2,
      CSR_LIN_MAX    = 3'd3,
      CSR_ANG_MIN    = 3'd4,
      CSR_ANG_MAX    = 3'd5,
      CSR_TRACK      = 3'd6,
      CSR_WHEEL_DIAM = 3'd7
   } csr_idx_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP_PREP,
      ST_MAP_GO,
      ST_MAP_WAIT,
      ST_MAP_SAVE,
      ST_MIX_MUL,
      ST_MIX_SUM,
      ST_MIX_SCALE,
      ST_RPM_GO,
      ST_RPM_WAIT,
      ST_RPM_SAVE,
      ST_EMIT
   } state_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NOP,
      OP_TAKE,
      OP_MAP_PREP,
      OP_MAP_GO,
      OP_MAP_SAVE,
      OP_MIX_MUL,
      OP_MIX_SUM,
      OP_MIX_SCALE,
      OP_RPM_GO,
      OP_RPM_SAVE,
      OP_EMIT
   } dp_op_type;

   // command from controller to datapath; sel picks forward/side or right/left
   typedef struct packed {
      dp_op_type op;
      logic      sel;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic div_busy;
      logic rsp_busy;
   } dp_stat_type;

endpackage

### rtl/rcdd_div.sv
module rcdd_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [rcdd_pkg::DIV_NUM_W-1:0]     num,
   input  logic [rcdd_pkg::DIV_DEN_W-1:0]     den,
   input  logic [rcdd_pkg::DIV_CNT_W-1:0]     iters,
   output logic                               busy,
   output logic [rcdd_pkg::DIV_NUM_W-1:0]     quo
);

   logic                              busy_ff, busy_in;
   logic [rcdd_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [rcdd_pkg::DIV_DEN_W-1:0]    rem_ff, rem_in;
   logic [rcdd_pkg::DIV_DEN_W-1:0]    den_ff, den_in;
   logic [rcdd_pkg::DIV_NUM_W-1:0]    num_ff, num_in;
   logic [rcdd_pkg::DIV_NUM_W-1:0]    quo_ff, quo_in;
   logic [rcdd_pkg::DIV_DEN_W:0]      trial;
   logic [rcdd_pkg::DIV_DEN_W:0]      diff;
   logic                              fits;

   // one restoring step: bring down the next dividend bit
   always_comb begin
      trial = {rem_ff, num_ff[rcdd_pkg::DIV_NUM_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = (trial >= {1'b0, den_ff});
   end

   // next values
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = iters;
         rem_in  = '0;
         den_in  = den;
         num_in  = num;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[rcdd_pkg::DIV_DEN_W-1:0] : trial[rcdd_pkg::DIV_DEN_W-1:0];
         num_in  = {num_ff[rcdd_pkg::DIV_NUM_W-2:0], 1'b0};
         quo_in  = {quo_ff[rcdd_pkg::DIV_NUM_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != rcdd_pkg::DIV_CNT_W'(1));
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

### rtl/rcdd_dp.sv
module rcdd_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  rcdd_pkg::dp_cmd_type cmd,
   output rcdd_pkg::dp_stat_type stat,
   input  logic                 req_mode,
   input  logic [31:0]          req_time,
   input  logic                 csr_we,
   input  logic [2:0]           csr_addr,
   input  logic [15:0]          csr_wdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata
);

   localparam int HW  = rcdd_pkg::HELD_W;
   localparam int NW  = rcdd_pkg::DIV_NUM_W;
   localparam int MW  = rcdd_pkg::MAP_MAG_W;

   // configuration registers
   logic [11:0]        pulse_min_ff, pulse_max_ff, track_ff, diam_ff;
   logic [15:0]        lin_min_ff, lin_max_ff, ang_min_ff, ang_max_ff;

   // channel state
   logic [31:0]        last_ff [2];
   logic [HW-1:0]      held_ff [2];

   // mapping stage
   logic [MW-1:0]      pmag_ff, pmag_in;
   logic [11:0]        smag_ff, smag_in;
   logic               pneg_ff, pneg_in;
   logic               dead_ff, dead_in;
   logic               empty_ff, empty_in;
   logic signed [29:0] vel_ff [2];
   logic signed [29:0] vel_in;

   // mixing stage
   logic signed [42:0] a_ff, a_in, b_ff, b_in;
   logic signed [42:0] sum_ff [2];
   logic [NW-1:0]      nmag_ff [2];
   logic               nneg_ff [2];
   logic [rcdd_pkg::DIV_DEN_W-1:0] den_ff, den_in;
   logic [15:0]        rpm_ff [2];
   logic [15:0]        rpm_in;

   // output register
   logic               rsp_valid_ff;
   logic [31:0]        rsp_data_ff;

   // divider hookup
   logic               div_start;
   logic [NW-1:0]      div_num;
   logic [rcdd_pkg::DIV_DEN_W-1:0] div_den;
   logic [rcdd_pkg::DIV_CNT_W-1:0] div_iters;
   logic               div_busy;
   logic [NW-1:0]      div_quo;

   // scratch
   logic [31:0]        dt;
   logic [11:0]        w12;
   logic signed [12:0] diff_c, span_c;
   logic signed [16:0] dout_c;
   logic signed [29:0] prod_c;
   logic [29:0]        prod_abs;
   logic [15:0]        omin_c, omax_c;
   logic signed [29:0] omin30, qs;
   logic [11:0]        dfix;
   logic signed [55:0] num_r_c, num_l_c;
   logic [55:0]        nabs_r, nabs_l;
   logic               rneg;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_min_ff <= 12'd1000;
         pulse_max_ff <= 12'd2000;
         lin_min_ff   <= 16'hFF00;
         lin_max_ff   <= 16'h0100;
         ang_min_ff   <= 16'hFF00;
         ang_max_ff   <= 16'h0100;
         track_ff     <= 12'd400;
         diam_ff      <= 12'd150;
      end else if (csr_we) begin
         unique case (rcdd_pkg::csr_idx_type'(csr_addr))
            rcdd_pkg::CSR_PULSE_MIN:  pulse_min_ff <= csr_wdata[11:0];
            rcdd_pkg::CSR_PULSE_MAX:  pulse_max_ff <= csr_wdata[11:0];
            rcdd_pkg::CSR_LIN_MIN:    lin_min_ff   <= csr_wdata;
            rcdd_pkg::CSR_LIN_MAX:    lin_max_ff   <= csr_wdata;
            rcdd_pkg::CSR_ANG_MIN:    ang_min_ff   <= csr_wdata;
            rcdd_pkg::CSR_ANG_MAX:    ang_max_ff   <= csr_wdata;
            rcdd_pkg::CSR_TRACK:      track_ff     <= csr_wdata[11:0];
            rcdd_pkg::CSR_WHEEL_DIAM: diam_ff      <= csr_wdata[11:0];
            default:                  pulse_min_ff <= pulse_min_ff;
         endcase
      end
   end

   // edge interval and held width update on request
   assign dt = req_time - last_ff[req_mode];

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff[0] <= '0;
         last_ff[1] <= '0;
         held_ff[0] <= '0;
         held_ff[1] <= '0;
      end else if (cmd.op == rcdd_pkg::OP_TAKE && req_time > last_ff[req_mode]) begin
         last_ff[req_mode] <= req_time;
         if (dt < 32'(rcdd_pkg::WIDTH_LIMIT_US)) begin
            held_ff[req_mode] <= dt[HW-1:0];
         end
      end
   end

   // output span for the channel at hand
   always_comb begin
      omin_c = cmd.sel ? ang_min_ff : lin_min_ff;
      omax_c = cmd.sel ? ang_max_ff : lin_max_ff;
      omin30 = $signed({{14{omin_c[15]}}, omin_c});
   end

   // map prep: scaled offset product, span, dead band and empty span flags
   always_comb begin
      w12      = 12'(held_ff[cmd.sel]);
      diff_c   = $signed({1'b0, w12}) - $signed({1'b0, pulse_min_ff});
      span_c   = $signed({1'b0, pulse_max_ff}) - $signed({1'b0, pulse_min_ff});
      dout_c   = $signed({omax_c[15], omax_c}) - $signed({omin_c[15], omin_c});
      prod_c   = diff_c * dout_c;
      prod_abs = prod_c[29] ? 30'(-prod_c) : prod_c;
      pmag_in  = prod_abs[MW-1:0];
      smag_in  = span_c[12] ? 12'(-span_c) : span_c[11:0];
      pneg_in  = prod_c[29] ^ span_c[12];
      dead_in  = (w12 >= rcdd_pkg::DEAD_LO) && (w12 <= rcdd_pkg::DEAD_HI);
      empty_in = (pulse_max_ff == pulse_min_ff);
   end

   // map result: signed quotient plus low end of range; zero in the dead band, low end if the span is empty
   always_comb begin
      qs = pneg_ff ? -$signed({2'b00, div_quo[MW-1:0]}) : $signed({2'b00, div_quo[MW-1:0]});
      if (dead_ff) begin
         vel_in = '0;
      end else if (empty_ff) begin
         vel_in = omin30;
      end else begin
         vel_in = qs + omin30;
      end
   end

   // mixing products and sums
   always_comb begin
      a_in    = vel_ff[0] * $signed({1'b0, rcdd_pkg::V_GAIN});
      b_in    = vel_ff[1] * $signed({1'b0, track_ff});
      num_r_c = sum_ff[0] * $signed({1'b0, rcdd_pkg::RPM_SCALE});
      num_l_c = sum_ff[1] * $signed({1'b0, rcdd_pkg::RPM_SCALE});
      nabs_r  = num_r_c[55] ? 56'(-num_r_c) : num_r_c;
      nabs_l  = num_l_c[55] ? 56'(-num_l_c) : num_l_c;
      dfix    = (diam_ff == 12'd0) ? 12'd1 : diam_ff;
      den_in  = {12'd0, rcdd_pkg::DEN_SCALE} * {17'd0, dfix};
   end

   // rpm: right is negated, both saturate to 16 bits
   always_comb begin
      rneg = cmd.sel ? nneg_ff[1] : ~nneg_ff[0];
      if (!rneg) begin
         rpm_in = (div_quo > NW'(32767)) ? 16'h7FFF : div_quo[15:0];
      end else begin
         rpm_in = (div_quo > NW'(32768)) ? 16'h8000 : (~div_quo[15:0] + 16'd1);
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.op == rcdd_pkg::OP_MAP_PREP) begin
         pmag_ff  <= pmag_in;
         smag_ff  <= smag_in;
         pneg_ff  <= pneg_in;
         dead_ff  <= dead_in;
         empty_ff <= empty_in;
      end
      if (cmd.op == rcdd_pkg::OP_MAP_SAVE) begin
         vel_ff[cmd.sel] <= vel_in;
      end
      if (cmd.op == rcdd_pkg::OP_MIX_MUL) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
      if (cmd.op == rcdd_pkg::OP_MIX_SUM) begin
         sum_ff[0] <= a_ff + b_ff;
         sum_ff[1] <= a_ff - b_ff;
      end
      if (cmd.op == rcdd_pkg::OP_MIX_SCALE) begin
         nmag_ff[0] <= nabs_r[NW-1:0];
         nmag_ff[1] <= nabs_l[NW-1:0];
         nneg_ff[0] <= num_r_c[55];
         nneg_ff[1] <= num_l_c[55];
         den_ff     <= den_in;
      end
      if (cmd.op == rcdd_pkg::OP_RPM_SAVE) begin
         rpm_ff[cmd.sel] <= rpm_in;
      end
   end

   // shared divider: map uses the top bits of the dividend only
   always_comb begin
      div_start = (cmd.op == rcdd_pkg::OP_MAP_GO) || (cmd.op == rcdd_pkg::OP_RPM_GO);
      if (cmd.op == rcdd_pkg::OP_MAP_GO) begin
         div_num   = {pmag_ff, (NW - MW)'(0)};
         div_den   = rcdd_pkg::DIV_DEN_W'(smag_ff);
         div_iters = rcdd_pkg::MAP_ITERS;
      end else begin
         div_num   = nmag_ff[cmd.sel];
         div_den   = den_ff;
         div_iters = rcdd_pkg::RPM_ITERS;
      end
   end

   rcdd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .iters (div_iters),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == rcdd_pkg::OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == rcdd_pkg::OP_EMIT) begin
         rsp_data_ff <= {rpm_ff[1], rpm_ff[0]};
      end
   end

   assign stat.div_busy = div_busy;
   assign stat.rsp_busy = rsp_valid_ff & ~rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;

endmodule

### rtl/rcdd_ctrl.sv
module rcdd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  rcdd_pkg::dp_stat_type stat,
   output rcdd_pkg::dp_cmd_type  cmd
);

   rcdd_pkg::state_type state_ff, state_in;
   logic                sel_ff, sel_in;

   // next state
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      unique case (state_ff)
         rcdd_pkg::ST_IDLE: begin
            sel_in = 1'b0;
            if (req_tvalid) begin
               state_in = rcdd_pkg::ST_MAP_PREP;
            end
         end
         rcdd_pkg::ST_MAP_PREP:  state_in = rcdd_pkg::ST_MAP_GO;
         rcdd_pkg::ST_MAP_GO:    state_in = rcdd_pkg::ST_MAP_WAIT;
         rcdd_pkg::ST_MAP_WAIT: begin
            if (!stat.div_busy) begin
               state_in = rcdd_pkg::ST_MAP_SAVE;
            end
         end
         rcdd_pkg::ST_MAP_SAVE: begin
            sel_in   = ~sel_ff;
            state_in = sel_ff ? rcdd_pkg::ST_MIX_MUL : rcdd_pkg::ST_MAP_PREP;
         end
         rcdd_pkg::ST_MIX_MUL:   state_in = rcdd_pkg::ST_MIX_SUM;
         rcdd_pkg::ST_MIX_SUM:   state_in = rcdd_pkg::ST_MIX_SCALE;
         rcdd_pkg::ST_MIX_SCALE: state_in = rcdd_pkg::ST_RPM_GO;
         rcdd_pkg::ST_RPM_GO:    state_in = rcdd_pkg::ST_RPM_WAIT;
         rcdd_pkg::ST_RPM_WAIT: begin
            if (!stat.div_busy) begin
               state_in = rcdd_pkg::ST_RPM_SAVE;
            end
         end
         rcdd_pkg::ST_RPM_SAVE: begin
            sel_in   = ~sel_ff;
            state_in = sel_ff ? rcdd_pkg::ST_EMIT : rcdd_pkg::ST_RPM_GO;
         end
         rcdd_pkg::ST_EMIT: begin
            if (!stat.rsp_busy) begin
               state_in = rcdd_pkg::ST_IDLE;
            end
         end
         default: state_in = rcdd_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.op     = rcdd_pkg::OP_NOP;
      cmd.sel    = sel_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         rcdd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = rcdd_pkg::OP_TAKE;
            end
         end
         rcdd_pkg::ST_MAP_PREP:  cmd.op = rcdd_pkg::OP_MAP_PREP;
         rcdd_pkg::ST_MAP_GO:    cmd.op = rcdd_pkg::OP_MAP_GO;
         rcdd_pkg::ST_MAP_WAIT:  cmd.op = rcdd_pkg::OP_NOP;
         rcdd_pkg::ST_MAP_SAVE:  cmd.op = rcdd_pkg::OP_MAP_SAVE;
         rcdd_pkg::ST_MIX_MUL:   cmd.op = rcdd_pkg::OP_MIX_MUL;
         rcdd_pkg::ST_MIX_SUM:   cmd.op = rcdd_pkg::OP_MIX_SUM;
         rcdd_pkg::ST_MIX_SCALE: cmd.op = rcdd_pkg::OP_MIX_SCALE;
         rcdd_pkg::ST_RPM_GO:    cmd.op = rcdd_pkg::OP_RPM_GO;
         rcdd_pkg::ST_RPM_WAIT:  cmd.op = rcdd_pkg::OP_NOP;
         rcdd_pkg::ST_RPM_SAVE:  cmd.op = rcdd_pkg::OP_RPM_SAVE;
         rcdd_pkg::ST_EMIT: begin
            if (!stat.rsp_busy) begin
               cmd.op = rcdd_pkg::OP_EMIT;
            end
         end
         default: cmd.op = rcdd_pkg::OP_NOP;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcdd_pkg::ST_IDLE;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

### rtl/rc_pulse_to_diff_drive_rpm.sv
// channel   dir  handshake              payload
// req_      in   req_tvalid/req_tready  tdata: edge_time_us; tuser: mode
// rsp_      out  rsp_tvalid/rsp_tready  tdata: right_rpm, left_rpm
// csr_      in   csr_we                 csr_addr, csr_wdata
//
// A request's result is valid once the one-bit-per-cycle divider, shared by
// two 28-step velocity divisions and two 55-step rpm divisions, has run all
// four in turn. The next request is taken once the result sits in the output
// register, even while that result waits for rsp_tready.
// Reset is synchronous and restores the register defaults and clears both
// channels' edge time and held width.
module rc_pulse_to_diff_drive_rpm (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] edge_time_us
   input  logic        req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] right_rpm, [31:16] left_rpm
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   rcdd_pkg::dp_cmd_type  cmd;
   rcdd_pkg::dp_stat_type stat;

   // sequencer
   rcdd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // arithmetic and state
   rcdd_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_mode   (req_tuser),
      .req_time   (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
